[src/sck_pkg.sv]
// ----------------------------------------------------------------------------
// sck_pkg
// Shared types and constants for the substitution cipher with key check.
// ----------------------------------------------------------------------------
package sck_pkg;

  localparam int unsigned KeyLen = 26;
  localparam int unsigned PosCap = 27;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] pos_t;
  typedef logic [KeyLen-1:0] seen_t;

  typedef enum logic [2:0] {
    ST_TEXT    = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_ACCEPT  = 3'd2,
    ST_BADCHAR = 3'd3,
    ST_LENGTH  = 3'd4,
    ST_DUP     = 3'd5,
    ST_NOKEY   = 3'd6
  } status_t;

  localparam logic       CMD_KEY   = 1'b0;
  localparam logic       CMD_TEXT  = 1'b1;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;

endpackage

[src/sck_channels.sv]
// ----------------------------------------------------------------------------
// sck_channels
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sck_item_if
  import sck_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic       last_of_key;

  modport source (output valid, output command, output data_byte, output last_of_key,
                  input ready);
  modport sink (input valid, input command, input data_byte, input last_of_key,
                output ready);
endinterface

interface sck_result_if
  import sck_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink (input valid, input out_byte, input status, output ready);
endinterface

[src/substitution_cipher_with_key_check.sv]
// ----------------------------------------------------------------------------
// substitution_cipher_with_key_check
// Monoalphabetic substitution cipher that validates and loads its own key.
// ----------------------------------------------------------------------------
// Requests arrive on the items channel, each a byte tagged as key or text.
// Every request yields exactly one result on the results channel, in order.
// Key bytes are checked as they arrive and written into a 26-entry key
// memory; the byte marked last gets the verdict on the whole key. Text
// letters are looked up in the key memory and keep their case.
// Each request passes through two register stages: the synchronous key
// memory read and the output register. Throughput is one request per cycle
// while the receiver does not stall; the key memory has one write port for
// key bytes and one read port for text bytes, and a text byte never reads an
// entry written by the key byte accepted in the same cycle.
// When the receiver stalls, the whole two-stage pipeline holds and the
// items channel drops ready until the held result is taken.
// Reset empties the pipeline and clears the key state; the key memory
// contents are not cleared, and text before a good key passes unchanged.
// ----------------------------------------------------------------------------
module substitution_cipher_with_key_check
  import sck_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sck_item_if.sink     items,
  sck_result_if.source results
);

  letter_t key_mem [KeyLen];
  letter_t rd_data;

  pos_t    key_position;
  seen_t   letters_seen;
  logic    bad_char_seen;
  logic    duplicate_seen;
  logic    key_ready;
  logic    loading_key;

  pos_t    key_position_next;
  seen_t   letters_seen_next;
  logic    bad_char_seen_next;
  logic    duplicate_seen_next;
  logic    key_ready_next;
  logic    loading_key_next;

  logic    s1_valid;
  logic    s1_map;
  logic    s1_lower;
  logic [7:0] s1_byte;
  status_t s1_status;

  logic    out_valid;
  logic [7:0] out_byte;
  status_t out_status;

  logic    advance;
  logic    accept;
  logic    is_upper;
  logic    is_lower;
  logic    is_letter;
  letter_t idx;
  logic    wr_en;
  pos_t    wr_addr;
  logic    rd_en;
  status_t st_next;
  pos_t    pos_base;
  seen_t   seen_base;
  logic    bad_base;
  logic    dup_base;
  letter_t cipher;

  assign advance = !out_valid || results.ready;
  assign items.ready = advance;
  assign accept = items.valid && advance;

  assign is_upper  = (items.data_byte >= UPPER_A) && (items.data_byte <= UPPER_Z);
  assign is_lower  = (items.data_byte >= LOWER_A) && (items.data_byte <= LOWER_Z);
  assign is_letter = is_upper || is_lower;
  assign idx = is_lower ? letter_t'(items.data_byte - LOWER_A)
                        : letter_t'(items.data_byte - UPPER_A);

  always_comb begin
    pos_base  = loading_key ? key_position : '0;
    seen_base = loading_key ? letters_seen : '0;
    bad_base  = loading_key && bad_char_seen;
    dup_base  = loading_key && duplicate_seen;

    key_position_next   = key_position;
    letters_seen_next   = letters_seen;
    bad_char_seen_next  = bad_char_seen;
    duplicate_seen_next = duplicate_seen;
    key_ready_next      = key_ready;
    loading_key_next    = loading_key;
    wr_en   = 1'b0;
    wr_addr = pos_base;
    rd_en   = 1'b0;
    st_next = ST_TEXT;

    if (accept && items.command == CMD_TEXT) begin
      rd_en   = key_ready && is_letter;
      st_next = key_ready ? ST_TEXT : ST_NOKEY;
    end else if (accept) begin
      letters_seen_next   = seen_base;
      bad_char_seen_next  = bad_base;
      duplicate_seen_next = dup_base;
      if (!is_letter) begin
        bad_char_seen_next = 1'b1;
      end else if (pos_base < pos_t'(KeyLen)) begin
        wr_en = 1'b1;
        duplicate_seen_next = dup_base || seen_base[idx];
        letters_seen_next   = seen_base | (seen_t'(1) << idx);
      end
      key_position_next = (pos_base < pos_t'(PosCap)) ? pos_base + pos_t'(1) : pos_base;

      if (items.last_of_key) begin
        loading_key_next = 1'b0;
        key_ready_next   = 1'b0;
        if (bad_char_seen_next) begin
          st_next = ST_BADCHAR;
        end else if (key_position_next != pos_t'(KeyLen)) begin
          st_next = ST_LENGTH;
        end else if (duplicate_seen_next) begin
          st_next = ST_DUP;
        end else begin
          st_next = ST_ACCEPT;
          key_ready_next = 1'b1;
        end
      end else begin
        loading_key_next = 1'b1;
        key_ready_next   = loading_key && key_ready;
        st_next          = ST_TAKEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= idx;
    end
    if (rd_en) begin
      rd_data <= key_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position   <= '0;
      letters_seen   <= '0;
      bad_char_seen  <= 1'b0;
      duplicate_seen <= 1'b0;
      key_ready      <= 1'b0;
      loading_key    <= 1'b0;
    end else begin
      key_position   <= key_position_next;
      letters_seen   <= letters_seen_next;
      bad_char_seen  <= bad_char_seen_next;
      duplicate_seen <= duplicate_seen_next;
      key_ready      <= key_ready_next;
      loading_key    <= loading_key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= items.valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_map    <= rd_en;
      s1_lower  <= is_lower;
      s1_byte   <= (items.command == CMD_TEXT) ? items.data_byte : 8'h00;
      s1_status <= st_next;
    end
  end

  assign cipher = (rd_data >= letter_t'(KeyLen)) ? rd_data - letter_t'(KeyLen) : rd_data;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= s1_status;
      if (s1_map) begin
        out_byte <= (s1_lower ? LOWER_A : UPPER_A) + {3'b000, cipher};
      end else begin
        out_byte <= s1_byte;
      end
    end
  end

  assign results.valid    = out_valid;
  assign results.out_byte = out_byte;
  assign results.status   = out_status;

endmodule

[src/sck_checker.sv]
// ----------------------------------------------------------------------------
// sck_checker
// Port-level checks on the substitution cipher, bound to the top level.
// ----------------------------------------------------------------------------
module sck_checker
  import sck_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_byte,
  input logic [2:0] res_status
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("Result valid dropped while stalled.");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_byte) && $stable(res_status))
    else $error("Result payload changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("Result valid after reset.");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_TEXT && res_status != ST_NOKEY |-> res_byte == 8'h00)
    else $error("Key result carries a nonzero byte.");

endmodule

bind substitution_cipher_with_key_check sck_checker u_sck_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_byte  (results.out_byte),
  .res_status(results.status)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the substitution cipher with key check.
// ----------------------------------------------------------------------------
// A few directed requests cover text sent before any key and the key verdicts
// on short and bad keys. Random key loads follow: good keys, keys with a
// repeated letter, short and long keys and keys holding a non-letter. Text
// bursts and stray text bytes are mixed in between and inside the key loads.
// A scoreboard class predicts one result per accepted request and checks
// each result against the oldest prediction. The sender works in bursts,
// and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import sck_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalRequests = 1550;
  localparam int DrainEvery = 300;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
  } cipher_result_t;

  class cipher_scoreboard;
    letter_t        key_table [KeyLen];
    pos_t           key_pos;
    seen_t          seen;
    bit             bad_char;
    bit             dup_letter;
    bit             key_ready;
    bit             loading;
    cipher_result_t results_due [$];
    int             mismatches;

    function new();
      foreach (key_table[i]) key_table[i] = '0;
      key_pos = '0;
      seen = '0;
      bad_char = 0;
      dup_letter = 0;
      key_ready = 0;
      loading = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void note_request(logic cmd, logic [7:0] b, logic last);
      logic           is_upper;
      logic           is_lower;
      letter_t        idx;
      cipher_result_t r;
      is_upper = (b >= UPPER_A) && (b <= UPPER_Z);
      is_lower = (b >= LOWER_A) && (b <= LOWER_Z);
      idx = is_upper ? letter_t'(b - UPPER_A) : letter_t'(b - LOWER_A);
      if (cmd == CMD_TEXT) begin
        r.out_byte = b;
        if (!key_ready) begin
          r.status = ST_NOKEY;
        end else begin
          r.status = ST_TEXT;
          if (is_upper || is_lower) begin
            r.out_byte = (is_lower ? LOWER_A : UPPER_A) + {3'b000, key_table[idx]};
          end
        end
      end else begin
        if (!loading) begin
          key_pos = '0;
          seen = '0;
          bad_char = 0;
          dup_letter = 0;
          key_ready = 0;
          loading = 1;
        end
        if (!(is_upper || is_lower)) begin
          bad_char = 1;
        end else if (key_pos < KeyLen) begin
          key_table[key_pos] = idx;
          if (seen[idx]) dup_letter = 1;
          seen[idx] = 1'b1;
        end
        if (key_pos < PosCap) key_pos = key_pos + 1'b1;
        r.out_byte = 8'h00;
        if (last) begin
          if (bad_char) begin
            r.status = ST_BADCHAR;
          end else if (key_pos != KeyLen) begin
            r.status = ST_LENGTH;
          end else if (dup_letter) begin
            r.status = ST_DUP;
          end else begin
            r.status = ST_ACCEPT;
            key_ready = 1;
          end
          loading = 0;
        end else begin
          r.status = ST_TAKEN;
        end
      end
      results_due.push_back(r);
    endfunction

    function void check_result(logic [7:0] ob, logic [2:0] st);
      cipher_result_t e;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: out_byte=%02h status=%0d", ob, st);
        return;
      end
      e = results_due.pop_front();
      if ((ob !== e.out_byte) || (st !== e.status)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected out_byte=%02h status=%0d,",
                   e.out_byte, e.status, " got out_byte=%02h status=%0d", ob, st);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  sck_item_if   items_if ();
  sck_result_if results_if ();

  substitution_cipher_with_key_check u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  cipher_scoreboard sb;
  int               cycle_count;
  int               sent;
  int               burst_left;
  int               stall_left;
  int               stall_mode;
  int               alphabet [KeyLen];
  logic [7:0]       key_bytes [$];

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.command = CMD_KEY;
    items_if.data_byte = 8'h00;
    items_if.last_of_key = 1'b0;
    results_if.ready = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && items_if.valid && items_if.ready)
      sb.note_request(items_if.command, items_if.data_byte, items_if.last_of_key);
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result(results_if.out_byte, results_if.status);
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    case (stall_mode)
      0: results_if.ready <= 1'b1;
      1: results_if.ready <= 1'($urandom_range(0, 1));
      2: results_if.ready <= ($urandom_range(0, 3) == 0);
      default: results_if.ready <= stall_left[0];
    endcase
  end

  function automatic logic [7:0] cased_letter(int idx);
    return ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'(idx);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= UPPER_A) && (b <= UPPER_Z)) || ((b >= LOWER_A) && (b <= LOWER_Z));
  endfunction

  function automatic logic [7:0] non_letter();
    logic [7:0] b;
    if ($urandom_range(0, 1)) return 8'($urandom_range(128, 255));
    do b = 8'($urandom_range(0, 127)); while (is_letter(b));
    return b;
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) < 7) return cased_letter($urandom_range(0, KeyLen - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_request(input logic cmd, input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        items_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    items_if.valid <= 1'b1;
    items_if.command <= cmd;
    items_if.data_byte <= b;
    items_if.last_of_key <= last;
    @(posedge clk);
    while (items_if.ready !== 1'b1) @(posedge clk);
    sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    items_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic shuffle_alphabet();
    int j;
    int t;
    foreach (alphabet[i]) alphabet[i] = i;
    for (int i = KeyLen - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = alphabet[i];
      alphabet[i] = alphabet[j];
      alphabet[j] = t;
    end
  endtask

  task automatic send_key();
    for (int i = 0; i < key_bytes.size(); i++) begin
      if ($urandom_range(0, 11) == 0)
        send_request(CMD_TEXT, text_byte(), 1'($urandom_range(0, 1)));
      send_request(CMD_KEY, key_bytes[i], i == key_bytes.size() - 1);
    end
  endtask

  task automatic send_random_sequence();
    int kind;
    int len;
    int j;
    int k;
    kind = $urandom_range(0, 99);
    key_bytes.delete();
    if (kind >= 65) begin
      len = $urandom_range(1, 24);
      repeat (len) send_request(CMD_TEXT, text_byte(), 1'($urandom_range(0, 1)));
      return;
    end
    shuffle_alphabet();
    foreach (alphabet[i]) key_bytes.push_back(cased_letter(alphabet[i]));
    if (kind >= 35 && kind < 45) begin
      j = $urandom_range(0, KeyLen - 1);
      do k = $urandom_range(0, KeyLen - 1); while (k == j);
      key_bytes[j] = cased_letter(alphabet[k]);
    end else if (kind >= 45 && kind < 52) begin
      len = $urandom_range(1, KeyLen - 1);
      while (key_bytes.size() > len) void'(key_bytes.pop_back());
    end else if (kind >= 52 && kind < 58) begin
      len = $urandom_range(1, 8);
      repeat (len) key_bytes.push_back(cased_letter($urandom_range(0, KeyLen - 1)));
    end else if (kind >= 58) begin
      key_bytes[$urandom_range(0, KeyLen - 1)] = non_letter();
      if ($urandom_range(0, 2) == 0) void'(key_bytes.pop_back());
    end
    send_key();
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    sent = 0;
    burst_left = 0;
    stall_left = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(CMD_TEXT, 8'h00, 1'b0);
    send_request(CMD_TEXT, 8'hFF, 1'b1);
    send_request(CMD_TEXT, UPPER_A, 1'b0);
    send_request(CMD_TEXT, LOWER_Z, 1'b1);
    send_request(CMD_TEXT, 8'h40, 1'b0);
    send_request(CMD_TEXT, 8'h5B, 1'b0);
    send_request(CMD_TEXT, 8'h60, 1'b0);
    send_request(CMD_TEXT, 8'h7B, 1'b0);
    send_request(CMD_KEY, 8'h7B, 1'b1);
    send_request(CMD_KEY, UPPER_A, 1'b0);
    send_request(CMD_TEXT, LOWER_A, 1'b0);
    send_request(CMD_KEY, UPPER_Z, 1'b1);
    send_request(CMD_KEY, 8'hFF, 1'b0);
    send_request(CMD_KEY, 8'h63, 1'b1);
    send_request(CMD_KEY, 8'h80, 1'b0);
    send_request(CMD_KEY, 8'h40, 1'b1);
    wait_for_results();

    while (sent < TotalRequests) begin
      send_random_sequence();
      if (sent / DrainEvery != (sent - 1) / DrainEvery || $urandom_range(0, 40) == 0)
        wait_for_results();
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
src/sck_pkg.sv
src/sck_channels.sv
src/substitution_cipher_with_key_check.sv
src/sck_checker.sv
bench/tb_top.sv
